/* hdl/ptphc_pkg.sv */
package ptphc_pkg;

  // Stream payload widths, packed and padded to whole bytes
  localparam int unsigned IN_TDATA_W  = 40;
  localparam int unsigned IN_TUSER_W  = 2;
  localparam int unsigned OUT_TDATA_W = 40;
  localparam int unsigned WORD_W      = 32;
  localparam int unsigned REG_IDX_W   = 4;
  localparam int unsigned STEP_W      = 4;
  localparam int unsigned CFG_IDX_W   = 2;

  // Transaction kinds carried in tuser
  localparam logic [1:0] MODE_TICK  = 2'd0;
  localparam logic [1:0] MODE_WRITE = 2'd1;
  localparam logic [1:0] MODE_READ  = 2'd2;

  // Word register map
  localparam logic [3:0] REG_TIME_LOW   = 4'd0;
  localparam logic [3:0] REG_TIME_MED   = 4'd1;
  localparam logic [3:0] REG_TIME_HIGH  = 4'd2;
  localparam logic [3:0] REG_DRIFT_PER  = 4'd3;
  localparam logic [3:0] REG_DRIFT_ACT  = 4'd4;
  localparam logic [3:0] REG_OFS_LOW    = 4'd5;
  localparam logic [3:0] REG_OFS_HIGH   = 4'd6;
  localparam logic [3:0] REG_OFS_DIR    = 4'd7;
  localparam logic [3:0] REG_PPS_EN     = 4'd8;

  // Drift actions
  localparam logic [1:0] DRIFT_OFF  = 2'd0;
  localparam logic [1:0] DRIFT_FAST = 2'd1;
  localparam logic [1:0] DRIFT_SLOW = 2'd2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_TICKS_PER_SEC = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TICK_STEP     = 2'd1;

  // Reset values of the configuration registers
  localparam logic [WORD_W-1:0] TPS_RESET  = 32'd125000000;
  localparam logic [STEP_W-1:0] STEP_RESET = 4'd2;

  // Status of the shared remainder unit
  typedef struct packed {
    logic busy;
    logic done;
  } rem_stat_t;

endpackage

/* hdl/ptp_hardware_clock_unit.sv */
// Channel   | Dir | Handshake                      | Payload
// s_axis    | in  | s_axis_tvalid / s_axis_tready  | tuser: mode; tdata: reg_index, write_data
// m_axis    | out | m_axis_tvalid / m_axis_tready  | tdata: read_data, pps_pulse
// cfg       | in  | cfg_valid_i / cfg_ready_o      | cfg_index_i, cfg_data_i
//
// Every transaction yields one result, registered in the cycle after acceptance.
// Ticks, reads and plain writes leave the sequencer idle. Setting the time, applying the
// offset, or a tick whose remainder folds more than once past a second runs
// the shared bit-serial remainder unit over all COUNTER_WIDTH dividend bits,
// then flags done and commits the result, unless ticks per second is zero;
// s_axis_tready is low meanwhile.
// Input is taken while a result waits, as long as m_axis drains in the same cycle.
// Reset is asynchronous, active low; the config port is always ready.
module ptp_hardware_clock_unit #(
  parameter int unsigned COUNTER_WIDTH = 64
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // tuser: mode[1:0]
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // tdata: reg_index[3:0], write_data[35:4], zero[39:36]
  input  logic [ptphc_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
  input  logic [ptphc_pkg::IN_TUSER_W-1:0]    s_axis_tuser,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // tdata: read_data[31:0], pps_pulse[32], zero[39:33]
  output logic [ptphc_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [ptphc_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [ptphc_pkg::WORD_W-1:0]        cfg_data_i
);
  import ptphc_pkg::*;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_REM  = 1'b1;

  logic                     state_q, state_d;
  logic [WORD_W-1:0]        tps_q;
  logic [STEP_W-1:0]        tick_step_q;
  logic [COUNTER_WIDTH-1:0] tick_cnt_q, tick_cnt_d;
  logic [COUNTER_WIDTH-1:0] latch_q, latch_d;
  logic [63:0]              set_q, set_d;
  logic [63:0]              ofs_q, ofs_d;
  logic [31:0]              drift_per_q, drift_per_d;
  logic [1:0]               drift_mode_q, drift_mode_d;
  logic [31:0]              drift_cnt_q, drift_cnt_d;
  logic [31:0]              rest_q, rest_d;
  logic                     pps_en_q, pps_en_d;
  logic                     out_valid_q, out_valid_d;
  logic [OUT_TDATA_W-1:0]   out_data_q, out_data_d;

  logic                     accept;
  logic [1:0]               in_mode;
  logic [REG_IDX_W-1:0]     in_idx;
  logic [WORD_W-1:0]        in_wdata;
  logic                     cfg_accept;

  logic                     drift_on;
  logic [31:0]              dc_next;
  logic                     drift_hit;
  logic [STEP_W:0]          step_eff;
  logic                     go_back;
  logic [COUNTER_WIDTH-1:0] tick_plus;
  logic [COUNTER_WIDTH-1:0] tick_minus1;
  logic [COUNTER_WIDTH-1:0] tick_ofs;
  logic [32:0]              sum;
  logic [32:0]              fold;
  logic                     over;
  logic                     fold_ok;
  logic [31:0]              back_rest;
  logic [63:0]              latch_ext;
  logic                     tps_zero;

  logic                     rem_start;
  logic [COUNTER_WIDTH-1:0] rem_dvd;
  rem_stat_t                rem_stat;
  logic [31:0]              rem_result;
  logic                     pulse;
  logic [31:0]              rd;

  assign accept     = s_axis_tvalid && s_axis_tready;
  assign in_mode    = s_axis_tuser;
  assign in_idx     = s_axis_tdata[REG_IDX_W-1:0];
  assign in_wdata   = s_axis_tdata[REG_IDX_W+WORD_W-1:REG_IDX_W];
  assign cfg_ready_o = 1'b1;
  assign cfg_accept = cfg_valid_i && cfg_ready_o;

  assign s_axis_tready = (state_q == ST_IDLE) && (!out_valid_q || m_axis_tready);

  // Drift decision for this tick
  assign drift_on  = (drift_mode_q == DRIFT_FAST) || (drift_mode_q == DRIFT_SLOW);
  assign dc_next   = drift_cnt_q + 32'd1;
  assign drift_hit = drift_on && (dc_next >= drift_per_q);
  assign go_back   = drift_hit && (drift_mode_q == DRIFT_SLOW) && (tick_step_q == '0);

  always_comb begin
    step_eff = {1'b0, tick_step_q};
    if (drift_hit && (drift_mode_q == DRIFT_FAST)) begin
      step_eff = step_eff + (STEP_W+1)'(1);
    end else if (drift_hit && (drift_mode_q == DRIFT_SLOW) && (tick_step_q != '0)) begin
      step_eff = step_eff - (STEP_W+1)'(1);
    end
  end

  // Counter candidates
  assign tick_plus   = tick_cnt_q + COUNTER_WIDTH'(step_eff);
  assign tick_minus1 = tick_cnt_q - COUNTER_WIDTH'(1);
  assign tick_ofs    = in_wdata[0] ? tick_cnt_q + ofs_q[COUNTER_WIDTH-1:0]
                                   : tick_cnt_q - ofs_q[COUNTER_WIDTH-1:0];

  // Remainder candidates; one subtraction covers the usual boundary crossing
  assign tps_zero  = (tps_q == '0);
  assign sum       = {1'b0, rest_q} + 33'(step_eff);
  assign over      = sum >= {1'b0, tps_q};
  assign fold      = sum - {1'b0, tps_q};
  assign fold_ok   = fold < {1'b0, tps_q};
  assign back_rest = ((rest_q == '0) || (rest_q >= tps_q)) ? tps_q - 32'd1
                                                           : rest_q - 32'd1;
  assign latch_ext = 64'(latch_q);

  always_comb begin
    state_d      = state_q;
    tick_cnt_d   = tick_cnt_q;
    latch_d      = latch_q;
    set_d        = set_q;
    ofs_d        = ofs_q;
    drift_per_d  = drift_per_q;
    drift_mode_d = drift_mode_q;
    drift_cnt_d  = drift_cnt_q;
    rest_d       = rest_q;
    pps_en_d     = pps_en_q;
    rem_start    = 1'b0;
    rem_dvd      = tick_cnt_q;
    pulse        = 1'b0;
    rd           = '0;

    // Take the recomputed remainder
    if (rem_stat.done) begin
      rest_d  = rem_result;
      state_d = ST_IDLE;
    end

    if (accept) begin
      case (in_mode)
        MODE_TICK: begin
          if (drift_on) begin
            drift_cnt_d = drift_hit ? 32'd0 : dc_next;
          end
          if (go_back) begin
            tick_cnt_d = tick_minus1;
            rest_d     = tps_zero ? 32'd0 : back_rest;
          end else begin
            tick_cnt_d = tick_plus;
            if (tps_zero) begin
              rest_d = '0;
            end else if (over) begin
              pulse = pps_en_q;
              if (fold_ok) begin
                rest_d = fold[31:0];
              end else begin
                rem_start = 1'b1;
                rem_dvd   = COUNTER_WIDTH'(sum);
              end
            end else begin
              rest_d = sum[31:0];
            end
          end
        end
        MODE_WRITE: begin
          case (in_idx)
            REG_TIME_LOW:  set_d[31:0]  = in_wdata;
            REG_TIME_MED:  set_d[63:32] = in_wdata;
            REG_TIME_HIGH: begin
              tick_cnt_d = set_q[COUNTER_WIDTH-1:0];
              rem_dvd    = set_q[COUNTER_WIDTH-1:0];
              rem_start  = !tps_zero;
              if (tps_zero) begin
                rest_d = '0;
              end
            end
            REG_DRIFT_PER: begin
              drift_per_d = in_wdata;
              drift_cnt_d = '0;
            end
            REG_DRIFT_ACT: begin
              drift_mode_d = in_wdata[1:0];
              drift_cnt_d  = '0;
            end
            REG_OFS_LOW:   ofs_d[31:0]  = in_wdata;
            REG_OFS_HIGH:  ofs_d[63:32] = in_wdata;
            REG_OFS_DIR: begin
              tick_cnt_d = tick_ofs;
              rem_dvd    = tick_ofs;
              rem_start  = !tps_zero;
              if (tps_zero) begin
                rest_d = '0;
              end
            end
            REG_PPS_EN:    pps_en_d = in_wdata[0];
            default: ;
          endcase
        end
        MODE_READ: begin
          case (in_idx)
            REG_TIME_LOW: begin
              latch_d = tick_cnt_q;
              rd      = tick_cnt_q[31:0];
            end
            REG_TIME_MED: rd = latch_ext[63:32];
            default:      rd = '0;
          endcase
        end
        default: ;
      endcase
      if (rem_start) begin
        state_d = ST_REM;
      end
    end
  end

  // Output register: load on acceptance, drop when taken
  always_comb begin
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    if (accept) begin
      out_valid_d = 1'b1;
      out_data_d  = OUT_TDATA_W'({pulse, rd});
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  ptphc_rem #(
    .DvdWidth (COUNTER_WIDTH)
  ) u_rem (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (rem_start),
    .dividend_i (rem_dvd),
    .divisor_i  (tps_q),
    .stat_o     (rem_stat),
    .rem_o      (rem_result)
  );

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tps_q       <= TPS_RESET;
      tick_step_q <= STEP_RESET;
    end else if (cfg_accept) begin
      case (cfg_index_i)
        CFG_TICKS_PER_SEC: tps_q       <= cfg_data_i;
        CFG_TICK_STEP:     tick_step_q <= cfg_data_i[STEP_W-1:0];
        default: ;
      endcase
    end
  end

  // Clock state and control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      tick_cnt_q   <= '0;
      latch_q      <= '0;
      set_q        <= '0;
      ofs_q        <= '0;
      drift_per_q  <= '0;
      drift_mode_q <= DRIFT_OFF;
      drift_cnt_q  <= '0;
      rest_q       <= '0;
      pps_en_q     <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      tick_cnt_q   <= tick_cnt_d;
      latch_q      <= latch_d;
      set_q        <= set_d;
      ofs_q        <= ofs_d;
      drift_per_q  <= drift_per_d;
      drift_mode_q <= drift_mode_d;
      drift_cnt_q  <= drift_cnt_d;
      rest_q       <= rest_d;
      pps_en_q     <= pps_en_d;
      out_valid_q  <= out_valid_d;
    end
  end

  // Result payload
  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  // No input while the remainder is being recomputed
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_REM) |-> !s_axis_tready)
    else $error("input accepted during remainder recompute");

  // The sequencer and the remainder unit agree on who is busy
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rem_stat.busy || rem_stat.done) |-> (state_q == ST_REM))
    else $error("remainder unit active outside recompute state");

  // Every accepted transaction leaves a result in the output register
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> out_valid_q)
    else $error("accepted transaction produced no result");

endmodule

/* hdl/ptphc_rem.sv */
module ptphc_rem #(
  parameter int unsigned DvdWidth = 64
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic [DvdWidth-1:0]   dividend_i,
  input  logic [31:0]           divisor_i,
  output ptphc_pkg::rem_stat_t  stat_o,
  output logic [31:0]           rem_o
);
  import ptphc_pkg::*;

  localparam int unsigned CntW = $clog2(DvdWidth + 1);

  logic [DvdWidth-1:0] dvd_q, dvd_d;
  logic [31:0]         dsr_q, dsr_d;
  logic [31:0]         rem_q, rem_d;
  logic [CntW-1:0]     cnt_q, cnt_d;
  logic                busy_q, busy_d;
  logic                done_q, done_d;

  logic [32:0]         shifted;
  logic [32:0]         diff;
  logic                geq;

  // One restoring step: shift in the next dividend bit, subtract if it fits
  assign shifted = {rem_q, dvd_q[DvdWidth-1]};
  assign diff    = shifted - {1'b0, dsr_q};
  assign geq     = shifted >= {1'b0, dsr_q};

  always_comb begin
    dvd_d  = dvd_q;
    dsr_d  = dsr_q;
    rem_d  = rem_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      dvd_d  = dividend_i;
      dsr_d  = divisor_i;
      rem_d  = '0;
      cnt_d  = CntW'(DvdWidth);
      busy_d = 1'b1;
    end else if (busy_q) begin
      dvd_d = {dvd_q[DvdWidth-2:0], 1'b0};
      rem_d = geq ? diff[31:0] : shifted[31:0];
      cnt_d = cnt_q - CntW'(1);
      if (cnt_q == CntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // Datapath
  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    dsr_q <= dsr_d;
    rem_q <= rem_d;
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign rem_o       = rem_q;

  // A new request never lands on a running one
  assert property (@(posedge clk_i) disable iff (!rst_ni) start_i |-> !busy_q)
    else $error("remainder unit restarted while busy");

  // A run always ends with a partial remainder below the divisor
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> (rem_q < dsr_q))
    else $error("remainder not below divisor");

endmodule
